// ----- sv/ssfla_pkg.sv -----
// package for the size sorted free list allocator
// types, constants and status codes used by the top level module
`timescale 1ns / 1ps

package ssfla_pkg;

  localparam int unsigned AddrW = 28;
  localparam int unsigned StatW = 3;
  localparam int unsigned BlockEntriesDef = 1024;
  localparam int unsigned FreeEntriesDef = 256;

  localparam logic [AddrW-1:0] HeapBaseReset = 28'h0700008;
  localparam logic [AddrW-1:0] HeapLimitReset = 28'hFFFFFFF;

  localparam logic RegHeapBase = 1'b0;
  localparam logic RegHeapLimit = 1'b1;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree = 1'b1;

  typedef enum logic [StatW-1:0] {
    StOk        = 3'd0,
    StZeroSize  = 3'd1,
    StExhausted = 3'd2,
    StTableFull = 3'd3,
    StNotFound  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FSCAN,
    S_FCHK,
    S_SHL_RD,
    S_SHL_WR,
    S_BUMP,
    S_BSCAN,
    S_BCHK,
    S_SZ_RD,
    S_SZ_WT,
    S_POS,
    S_POS_CHK,
    S_SHR_RD,
    S_SHR_WR,
    S_INS,
    S_DONE
  } state_t;

endpackage

// ----- sv/ssfla_ram.sv -----
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ssfla_ram #(
  parameter int unsigned Width = 28,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // read before write, registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/size_sorted_free_list_allocator_unit.sv -----
// top level of the size sorted free list allocator
// uses ssfla_pkg and ssfla_ram for the block and free tables
//
// channel  dir  handshake          fields
// in       in   in_valid/in_ready  mode, req_size, free_address
// out      out  out_valid/out_ready block_address, status, reused
// cfg      in   cfg_we             cfg_index, cfg_data
//
// one word at a time; a sequencer walks the tables through one shared comparator
// alloc: scans the free entries, then shifts the entries after a reused one down
// free: scans the block entries, then ranks the free entries by size and shifts
// the larger ones up to open a slot for the new entry
// reset is synchronous and needs no clearing pass; tables are valid below the counts
// in_ready is low from accept until the result word is taken
`timescale 1ns / 1ps

module size_sorted_free_list_allocator_unit #(
  parameter int unsigned BLOCK_ENTRIES = ssfla_pkg::BlockEntriesDef,
  parameter int unsigned FREE_ENTRIES = ssfla_pkg::FreeEntriesDef
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [ssfla_pkg::AddrW-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [ssfla_pkg::AddrW-1:0] req_size,
  input  logic [ssfla_pkg::AddrW-1:0] free_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ssfla_pkg::AddrW-1:0] block_address,
  output logic [ssfla_pkg::StatW-1:0] status,
  output logic                       reused
);

  localparam int unsigned AW = ssfla_pkg::AddrW;
  localparam int unsigned BIW = $clog2(BLOCK_ENTRIES);
  localparam int unsigned FIW = $clog2(FREE_ENTRIES);
  localparam int unsigned BCW = $clog2(BLOCK_ENTRIES + 1);
  localparam int unsigned FCW = $clog2(FREE_ENTRIES + 1);

  ssfla_pkg::state_t state, state_next;

  logic [AW-1:0] heap_base, heap_limit, heap_top;
  logic          heap_started;
  logic [BCW-1:0] block_count;
  logic [FCW-1:0] free_count;
  logic [FCW-1:0] idx;
  logic [FCW-1:0] sidx;
  logic [BCW-1:0] bidx;
  logic [AW-1:0] req_sz, req_addr, hold_addr, hold_size;

  // ram ports
  logic           ba_we, bs_we, fa_we, fs_we;
  logic [BIW-1:0] b_addr;
  logic [FIW-1:0] f_addr;
  logic [AW-1:0]  ba_rd, bs_rd, fa_rd, fs_rd, fa_wd, fs_wd;

  ssfla_ram #(.Width(AW), .Depth(BLOCK_ENTRIES)) u_baddr (
    .clk(clk), .we(ba_we), .addr(b_addr), .wdata(heap_started ? heap_top : heap_base),
    .rdata(ba_rd));
  ssfla_ram #(.Width(AW), .Depth(BLOCK_ENTRIES)) u_bsize (
    .clk(clk), .we(bs_we), .addr(b_addr), .wdata(req_sz), .rdata(bs_rd));
  ssfla_ram #(.Width(AW), .Depth(FREE_ENTRIES)) u_faddr (
    .clk(clk), .we(fa_we), .addr(f_addr), .wdata(fa_wd), .rdata(fa_rd));
  ssfla_ram #(.Width(AW), .Depth(FREE_ENTRIES)) u_fsize (
    .clk(clk), .we(fs_we), .addr(f_addr), .wdata(fs_wd), .rdata(fs_rd));

  // shared compare unit
  logic [AW-1:0] cmp_a, cmp_b;
  logic          cmp_ge, cmp_eq;
  assign cmp_ge = cmp_a >= cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  // bump arithmetic
  logic [AW-1:0] bump_addr;
  logic [AW:0]   bump_end;
  assign bump_addr = heap_started ? heap_top : heap_base;
  assign bump_end = {1'b0, bump_addr} + {1'b0, req_sz};

  logic at_free_end, at_block_end, last_shl;
  assign at_free_end = idx == free_count;
  assign at_block_end = bidx == block_count;
  assign last_shl = (idx + FCW'(1)) >= free_count;

  // compare operand selection
  always_comb begin
    cmp_a = fs_rd;
    cmp_b = req_sz;
    if (state == ssfla_pkg::S_BCHK) begin
      cmp_a = ba_rd;
      cmp_b = req_addr;
    end else if (state == ssfla_pkg::S_POS_CHK) begin
      cmp_a = fs_rd;
      cmp_b = hold_size;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ssfla_pkg::S_IDLE:
        if (in_valid) begin
          if (mode == ssfla_pkg::ModeFree) state_next = ssfla_pkg::S_BSCAN;
          else if (req_size == '0) state_next = ssfla_pkg::S_DONE;
          else state_next = ssfla_pkg::S_FSCAN;
        end
      ssfla_pkg::S_FSCAN:
        state_next = at_free_end ? ssfla_pkg::S_BUMP : ssfla_pkg::S_FCHK;
      ssfla_pkg::S_FCHK:
        state_next = cmp_ge ? ssfla_pkg::S_SHL_RD : ssfla_pkg::S_FSCAN;
      ssfla_pkg::S_SHL_RD:
        state_next = last_shl ? ssfla_pkg::S_DONE : ssfla_pkg::S_SHL_WR;
      ssfla_pkg::S_SHL_WR:
        state_next = ssfla_pkg::S_SHL_RD;
      ssfla_pkg::S_BUMP:
        state_next = ssfla_pkg::S_DONE;
      ssfla_pkg::S_BSCAN:
        state_next = at_block_end ? ssfla_pkg::S_DONE : ssfla_pkg::S_BCHK;
      ssfla_pkg::S_BCHK:
        state_next = cmp_eq ? ssfla_pkg::S_SZ_RD : ssfla_pkg::S_BSCAN;
      ssfla_pkg::S_SZ_RD:
        state_next = ssfla_pkg::S_SZ_WT;
      ssfla_pkg::S_SZ_WT:
        state_next = (free_count == FCW'(FREE_ENTRIES)) ? ssfla_pkg::S_DONE
                                                       : ssfla_pkg::S_POS;
      ssfla_pkg::S_POS:
        state_next = at_free_end ? ssfla_pkg::S_INS : ssfla_pkg::S_POS_CHK;
      ssfla_pkg::S_POS_CHK:
        state_next = cmp_ge ? ssfla_pkg::S_SHR_RD : ssfla_pkg::S_POS;
      ssfla_pkg::S_SHR_RD:
        state_next = ssfla_pkg::S_SHR_WR;
      ssfla_pkg::S_SHR_WR:
        state_next = ((sidx - FCW'(1)) == idx) ? ssfla_pkg::S_INS : ssfla_pkg::S_SHR_RD;
      ssfla_pkg::S_INS:
        state_next = ssfla_pkg::S_DONE;
      ssfla_pkg::S_DONE:
        if (out_ready) state_next = ssfla_pkg::S_IDLE;
      default: state_next = ssfla_pkg::S_IDLE;
    endcase
  end

  // ram controls; in the right shift sidx holds the write slot
  always_comb begin
    ba_we = 1'b0;
    bs_we = 1'b0;
    fa_we = 1'b0;
    fs_we = 1'b0;
    b_addr = bidx[BIW-1:0];
    f_addr = idx[FIW-1:0];
    fa_wd = fa_rd;
    fs_wd = fs_rd;
    case (state)
      ssfla_pkg::S_SHL_RD: f_addr = FIW'(idx + FCW'(1));
      ssfla_pkg::S_SHL_WR: begin
        fa_we = 1'b1;
        fs_we = 1'b1;
      end
      ssfla_pkg::S_BUMP: begin
        b_addr = block_count[BIW-1:0];
        ba_we = !bump_end[AW] && bump_end[AW-1:0] <= heap_limit
                && block_count != BCW'(BLOCK_ENTRIES);
        bs_we = ba_we;
      end
      ssfla_pkg::S_SHR_RD: f_addr = FIW'(sidx - FCW'(1));
      ssfla_pkg::S_SHR_WR: begin
        f_addr = FIW'(sidx);
        fa_we = 1'b1;
        fs_we = 1'b1;
      end
      ssfla_pkg::S_INS: begin
        fa_we = 1'b1;
        fs_we = 1'b1;
        fa_wd = req_addr;
        fs_wd = hold_size;
      end
      default: ;
    endcase
  end

  assign in_ready = state == ssfla_pkg::S_IDLE;
  assign out_valid = state == ssfla_pkg::S_DONE;
  assign block_address = hold_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= ssfla_pkg::HeapBaseReset;
      heap_limit <= ssfla_pkg::HeapLimitReset;
    end else if (cfg_we) begin
      if (cfg_index == ssfla_pkg::RegHeapBase) heap_base <= cfg_data;
      else heap_limit <= cfg_data;
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssfla_pkg::S_IDLE;
      heap_top <= '0;
      heap_started <= 1'b0;
      block_count <= '0;
      free_count <= '0;
    end else begin
      state <= state_next;
      case (state)
        ssfla_pkg::S_IDLE:
          if (in_valid) begin
            req_sz <= req_size;
            req_addr <= free_address;
            idx <= '0;
            bidx <= '0;
            hold_addr <= '0;
            reused <= 1'b0;
            status <= (mode == ssfla_pkg::ModeAlloc && req_size == '0)
                      ? ssfla_pkg::StZeroSize : ssfla_pkg::StOk;
          end
        ssfla_pkg::S_FCHK:
          if (cmp_ge) begin
            hold_addr <= fa_rd;
            reused <= 1'b1;
          end else idx <= idx + FCW'(1);
        ssfla_pkg::S_SHL_RD:
          if (last_shl) free_count <= free_count - FCW'(1);
        ssfla_pkg::S_SHL_WR: idx <= idx + FCW'(1);
        ssfla_pkg::S_BUMP:
          if (bump_end[AW] || bump_end[AW-1:0] > heap_limit) begin
            status <= ssfla_pkg::StExhausted;
          end else if (block_count == BCW'(BLOCK_ENTRIES)) begin
            status <= ssfla_pkg::StTableFull;
          end else begin
            hold_addr <= bump_addr;
            heap_top <= bump_end[AW-1:0];
            heap_started <= 1'b1;
            block_count <= block_count + BCW'(1);
          end
        ssfla_pkg::S_BSCAN:
          if (at_block_end) status <= ssfla_pkg::StNotFound;
        ssfla_pkg::S_BCHK:
          if (!cmp_eq) bidx <= bidx + BCW'(1);
        ssfla_pkg::S_SZ_WT: begin
          hold_size <= bs_rd;
          if (free_count == FCW'(FREE_ENTRIES)) status <= ssfla_pkg::StTableFull;
        end
        ssfla_pkg::S_POS_CHK:
          if (cmp_ge) sidx <= free_count;
          else idx <= idx + FCW'(1);
        ssfla_pkg::S_SHR_WR: sidx <= sidx - FCW'(1);
        ssfla_pkg::S_INS: free_count <= free_count + FCW'(1);
        default: ;
      endcase
    end
  end

endmodule
